// ===== rtl/core/aad_pkg.sv =====
// shared constants, codes and types of the area averaging downsampler
package aad_pkg;

  localparam int MAX_LENGTH  = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;

  localparam int LEN_W  = 13;
  localparam int BW_W   = 29;
  localparam int WS_W   = 17;
  localparam int AVG_W  = 16;
  localparam int IDX_W  = 12;
  localparam int CFG_W  = BW_W;
  localparam int CIDX_W = 2;
  localparam int CMP_W  = 32;

  localparam int POS_W = $clog2(MAX_LENGTH);
  localparam int CNT_W = POS_W + 1;
  localparam int BE_W  = BW_W + 2;
  localparam int FR_W  = FRAC_BITS + 1;
  localparam int W_W   = FR_W + WS_W - FRAC_BITS;
  localparam int MA_W  = (W_W > FR_W) ? W_W : FR_W;
  localparam int MB_W  = (WS_W > SAMPLE_BITS) ? WS_W : SAMPLE_BITS;
  localparam int MP_W  = MA_W + MB_W;
  localparam int ACC_W = 36;
  localparam int SUM_W = ACC_W + 1;

  localparam int AVG_SHIFT = 16;
  localparam int AQ_W      = SUM_W - AVG_SHIFT;

  localparam logic [FR_W-1:0]        ONE_FRAC   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FR_W-1:0]        MIN_FRAC   = FR_W'((1 << FRAC_BITS) / 1000);
  localparam logic [MP_W:0]          HALF_POS   = (MP_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [SUM_W-1:0]       HALF_AVG   = SUM_W'(1) << (AVG_SHIFT - 1);
  localparam logic [ACC_W-1:0]       ACC_MAX    = {ACC_W{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_SRC_LEN = 2'd0;
  localparam logic [CIDX_W-1:0] REG_DST_LEN = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BIN_W   = 2'd2;
  localparam logic [CIDX_W-1:0] REG_WSCALE  = 2'd3;

  // shared unit operations
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_WEIGHT = 2'd1;
  localparam logic [1:0] OP_MAC    = 2'd2;
  localparam logic [1:0] OP_CLR    = 2'd3;

  typedef struct packed {
    logic [1:0]             op;
    logic [FR_W-1:0]        frac;
    logic [SAMPLE_BITS-1:0] value;
  } mac_cmd_t;

endpackage

// ===== rtl/core/aad_mac.sv =====
// shared multiplier with weight register and saturating accumulator
module aad_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  aad_pkg::mac_cmd_t             cmd,
  input  logic [aad_pkg::WS_W-1:0]      weight_scale,
  output logic [aad_pkg::ACC_W-1:0]     acc
);

  logic [aad_pkg::MA_W-1:0]  mul_a;
  logic [aad_pkg::MB_W-1:0]  mul_b;
  logic [aad_pkg::MP_W-1:0]  prod;
  logic [aad_pkg::MP_W:0]    rounded;
  logic [aad_pkg::SUM_W-1:0] sum;
  logic [aad_pkg::W_W-1:0]   w_r;
  logic [aad_pkg::ACC_W-1:0] acc_r;
  logic [aad_pkg::ACC_W-1:0] acc_nxt;

  always_comb begin
    if (cmd.op == aad_pkg::OP_MAC) begin
      mul_a = aad_pkg::MA_W'(w_r);
      mul_b = aad_pkg::MB_W'(cmd.value);
    end else begin
      mul_a = aad_pkg::MA_W'(cmd.frac);
      mul_b = aad_pkg::MB_W'(weight_scale);
    end
  end

  assign prod    = aad_pkg::MP_W'(mul_a) * aad_pkg::MP_W'(mul_b);
  assign rounded = {1'b0, prod} + aad_pkg::HALF_POS;
  assign sum     = {1'b0, acc_r} + aad_pkg::SUM_W'(prod);

  always_comb begin
    case (cmd.op)
      aad_pkg::OP_MAC: acc_nxt = sum[aad_pkg::ACC_W] ? aad_pkg::ACC_MAX
                                                     : sum[aad_pkg::ACC_W-1:0];
      aad_pkg::OP_CLR: acc_nxt = '0;
      default:         acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == aad_pkg::OP_WEIGHT) begin
      w_r <= rounded[aad_pkg::FRAC_BITS +: aad_pkg::W_W];
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/core/aad_seq.sv =====
// sequencer: column position, bin bookkeeping and output register
module aad_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [15:0]                      in_sample,
  input  logic                             in_column_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [aad_pkg::AVG_W-1:0]        out_average,
  output logic [aad_pkg::IDX_W-1:0]        out_index,
  output logic                             out_last,
  input  logic                             restart,
  input  logic [aad_pkg::CNT_W-1:0]        src_eff,
  input  logic [aad_pkg::CNT_W-1:0]        dst_eff,
  input  logic [aad_pkg::BW_W-1:0]         bw_eff,
  input  logic [aad_pkg::ACC_W-1:0]        acc,
  output aad_pkg::mac_cmd_t                cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WGT  = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                        state_r, state_nxt;
  logic [aad_pkg::POS_W-1:0]         pos_r, pos_nxt;
  logic [aad_pkg::BE_W-1:0]          bin_end_r, bin_end_nxt;
  logic [aad_pkg::CNT_W-1:0]         bin_num_r, bin_num_nxt;
  logic [aad_pkg::SAMPLE_BITS-1:0]   value_r, value_nxt;
  logic [aad_pkg::FR_W-1:0]          frac_r, frac_nxt;
  logic [aad_pkg::FR_W-1:0]          tail_r, tail_nxt;
  logic                              end_col_r, end_col_nxt;
  logic                              straddle_r, straddle_nxt;
  logic                              tail_ph_r, tail_ph_nxt;
  logic                              emitted_r, emitted_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [aad_pkg::AVG_W-1:0]         out_avg_r, out_avg_nxt;
  logic [aad_pkg::IDX_W-1:0]         out_idx_r, out_idx_nxt;
  logic                              out_last_r, out_last_nxt;

  logic [aad_pkg::BE_W-1:0]          start;
  logic [aad_pkg::BE_W-1:0]          stop;
  logic                              straddle;
  logic [aad_pkg::FR_W-1:0]          head_frac;
  logic [aad_pkg::FR_W-1:0]          tail;
  logic                              end_col;
  logic                              bins_open;
  logic                              slot_free;
  logic [aad_pkg::CNT_W-1:0]         bin_num_inc;
  logic [aad_pkg::SUM_W-1:0]         avg_sum;
  logic [aad_pkg::AQ_W-1:0]          avg_q;
  logic [aad_pkg::SAMPLE_BITS-1:0]   avg_sat;

  assign start     = aad_pkg::BE_W'({pos_r, {aad_pkg::FRAC_BITS{1'b0}}});
  assign stop      = start + aad_pkg::BE_W'(aad_pkg::ONE_FRAC);
  assign straddle  = !(stop < bin_end_r);
  assign head_frac = straddle ? aad_pkg::FR_W'(bin_end_r - start) : aad_pkg::ONE_FRAC;
  assign tail      = aad_pkg::FR_W'(stop - bin_end_r);
  assign end_col   = in_column_end ||
                     (({1'b0, pos_r} + aad_pkg::CNT_W'(1)) >= src_eff);
  assign bins_open   = bin_num_r < dst_eff;
  assign slot_free   = !out_valid_r || out_ready;
  assign bin_num_inc = bin_num_r + aad_pkg::CNT_W'(1);

  // round to Q16.0 and saturate
  assign avg_sum = {1'b0, acc} + aad_pkg::HALF_AVG;
  assign avg_q   = avg_sum[aad_pkg::SUM_W-1:aad_pkg::AVG_SHIFT];
  assign avg_sat = (avg_q > aad_pkg::AQ_W'(aad_pkg::SAMPLE_MAX)) ? aad_pkg::SAMPLE_MAX
                 : avg_q[aad_pkg::SAMPLE_BITS-1:0];

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    bin_end_nxt   = bin_end_r;
    bin_num_nxt   = bin_num_r;
    value_nxt     = value_r;
    frac_nxt      = frac_r;
    tail_nxt      = tail_r;
    end_col_nxt   = end_col_r;
    straddle_nxt  = straddle_r;
    tail_ph_nxt   = tail_ph_r;
    emitted_nxt   = emitted_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_avg_nxt   = out_avg_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    cmd.op        = aad_pkg::OP_NONE;
    cmd.frac      = frac_r;
    cmd.value     = value_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          value_nxt    = in_sample[aad_pkg::SAMPLE_BITS-1:0];
          end_col_nxt  = end_col;
          straddle_nxt = straddle;
          frac_nxt     = head_frac;
          tail_nxt     = tail;
          tail_ph_nxt  = 1'b0;
          emitted_nxt  = 1'b0;
          if (!bins_open) begin
            state_nxt = S_FIN;
          end else if (head_frac > aad_pkg::MIN_FRAC) begin
            state_nxt = S_WGT;
          end else if (straddle) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_WGT: begin
        cmd.op    = aad_pkg::OP_WEIGHT;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.op = aad_pkg::OP_MAC;
        if (tail_ph_r || !straddle_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = aad_pkg::AVG_W'(avg_sat);
          out_idx_nxt   = bin_num_r[aad_pkg::IDX_W-1:0];
          out_last_nxt  = (bin_num_inc == dst_eff) || end_col_r;
          cmd.op        = aad_pkg::OP_CLR;
          bin_num_nxt   = bin_num_inc;
          bin_end_nxt   = bin_end_r + aad_pkg::BE_W'(bw_eff);
          emitted_nxt   = 1'b1;
          // the part past the bin end opens the next bin
          if ((bin_num_inc < dst_eff) && (tail_r > aad_pkg::MIN_FRAC)) begin
            frac_nxt    = tail_r;
            tail_ph_nxt = 1'b1;
            state_nxt   = S_WGT;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (end_col_r && !emitted_r && bins_open) begin
          // flush the open bin at column end
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_avg_nxt   = aad_pkg::AVG_W'(avg_sat);
            out_idx_nxt   = bin_num_r[aad_pkg::IDX_W-1:0];
            out_last_nxt  = 1'b1;
            cmd.op        = aad_pkg::OP_CLR;
            pos_nxt       = '0;
            bin_end_nxt   = aad_pkg::BE_W'(bw_eff);
            bin_num_nxt   = '0;
            state_nxt     = S_IDLE;
          end
        end else begin
          if (end_col_r) begin
            cmd.op      = aad_pkg::OP_CLR;
            pos_nxt     = '0;
            bin_end_nxt = aad_pkg::BE_W'(bw_eff);
            bin_num_nxt = '0;
          end else begin
            pos_nxt = pos_r + aad_pkg::POS_W'(1);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (restart) begin
      cmd.op      = aad_pkg::OP_CLR;
      pos_nxt     = '0;
      bin_end_nxt = aad_pkg::BE_W'(bw_eff);
      bin_num_nxt = '0;
      state_nxt   = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      bin_end_r   <= aad_pkg::BE_W'(aad_pkg::ONE_FRAC);
      bin_num_r   <= '0;
      end_col_r   <= 1'b0;
      straddle_r  <= 1'b0;
      tail_ph_r   <= 1'b0;
      emitted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      bin_end_r   <= bin_end_nxt;
      bin_num_r   <= bin_num_nxt;
      end_col_r   <= end_col_nxt;
      straddle_r  <= straddle_nxt;
      tail_ph_r   <= tail_ph_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    frac_r     <= frac_nxt;
    tail_r     <= tail_nxt;
    out_avg_r  <= out_avg_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_average = out_avg_r;
  assign out_index   = out_idx_r;
  assign out_last    = out_last_r;

endmodule

// ===== rtl/core/area_average_downsampler.sv =====
// top level of the one-dimensional area averaging downsampler
//
// Source samples of one column enter on the in_ valid/ready channel, one
// transaction each, with in_column_end on the last sample of the column.
// Each finished output bin leaves on the out_ valid/ready channel with its
// bin index and out_last on the final bin of the column.
// A sample that falls inside one bin is accepted, weighted and closed out;
// one that straddles a bin end gets a head part, a result and a tail part.
// Each weighted part uses the single shared multiplier twice, once for the
// weight and once for weight times sample; in_ready is high only while the
// sequencer is idle.
// A result sits in the output register; the next sample is still accepted
// while it waits, and the sequencer only holds when a second result is due
// before out_ready takes the first.
// Configuration writes on cfg_we take effect at once and restart the column.
// Synchronous reset loads the register defaults and restarts the column.
module area_average_downsampler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [15:0]                       in_sample,
  input  logic                              in_column_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       out_average,
  output logic [11:0]                       out_index,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [aad_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [aad_pkg::CFG_W-1:0]         cfg_wdata
);

  logic [aad_pkg::LEN_W-1:0] src_len_r, src_len_nxt;
  logic [aad_pkg::LEN_W-1:0] dst_len_r, dst_len_nxt;
  logic [aad_pkg::BW_W-1:0]  bin_w_r, bin_w_nxt;
  logic [aad_pkg::WS_W-1:0]  wscale_r, wscale_nxt;

  logic [aad_pkg::CNT_W-1:0] src_eff;
  logic [aad_pkg::CNT_W-1:0] dst_eff;
  logic [aad_pkg::BW_W-1:0]  bw_eff;
  logic [aad_pkg::ACC_W-1:0] acc;
  aad_pkg::mac_cmd_t         cmd;

  always_comb begin
    src_len_nxt = src_len_r;
    dst_len_nxt = dst_len_r;
    bin_w_nxt   = bin_w_r;
    wscale_nxt  = wscale_r;
    if (cfg_we) begin
      case (cfg_index)
        aad_pkg::REG_SRC_LEN: src_len_nxt = cfg_wdata[aad_pkg::LEN_W-1:0];
        aad_pkg::REG_DST_LEN: dst_len_nxt = cfg_wdata[aad_pkg::LEN_W-1:0];
        aad_pkg::REG_BIN_W:   bin_w_nxt   = cfg_wdata[aad_pkg::BW_W-1:0];
        aad_pkg::REG_WSCALE:  wscale_nxt  = cfg_wdata[aad_pkg::WS_W-1:0];
        default:              src_len_nxt = src_len_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_len_r <= aad_pkg::LEN_W'(1);
      dst_len_r <= aad_pkg::LEN_W'(1);
      bin_w_r   <= aad_pkg::BW_W'(aad_pkg::ONE_FRAC);
      wscale_r  <= aad_pkg::WS_W'(aad_pkg::ONE_FRAC);
    end else begin
      src_len_r <= src_len_nxt;
      dst_len_r <= dst_len_nxt;
      bin_w_r   <= bin_w_nxt;
      wscale_r  <= wscale_nxt;
    end
  end

  // effective lengths and bin width, taken from the values being written
  always_comb begin
    if (src_len_nxt == '0) begin
      src_eff = aad_pkg::CNT_W'(1);
    end else if (aad_pkg::CMP_W'(src_len_nxt) > aad_pkg::CMP_W'(aad_pkg::MAX_LENGTH)) begin
      src_eff = aad_pkg::CNT_W'(aad_pkg::MAX_LENGTH);
    end else begin
      src_eff = aad_pkg::CNT_W'(src_len_nxt);
    end

    if (dst_len_nxt == '0) begin
      dst_eff = aad_pkg::CNT_W'(1);
    end else if (aad_pkg::CMP_W'(dst_len_nxt) > aad_pkg::CMP_W'(src_eff)) begin
      dst_eff = src_eff;
    end else begin
      dst_eff = aad_pkg::CNT_W'(dst_len_nxt);
    end

    if (bin_w_nxt < aad_pkg::BW_W'(aad_pkg::ONE_FRAC)) begin
      bw_eff = aad_pkg::BW_W'(aad_pkg::ONE_FRAC);
    end else begin
      bw_eff = bin_w_nxt;
    end
  end

  aad_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_column_end (in_column_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_average   (out_average),
    .out_index     (out_index),
    .out_last      (out_last),
    .restart       (cfg_we),
    .src_eff       (src_eff),
    .dst_eff       (dst_eff),
    .bw_eff        (bw_eff),
    .acc           (acc),
    .cmd           (cmd)
  );

  aad_mac u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .weight_scale (wscale_r),
    .acc          (acc)
  );

  // a sample is never followed by another in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !cfg_we |=> !in_ready)
    else $error("sequencer accepted back-to-back samples");

  // a configuration write leaves an empty accumulator
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> acc == '0)
    else $error("accumulator not cleared on restart");

  // the block is idle right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

// ===== test/area_average_downsampler_tb.sv =====
// self-checking testbench of the area averaging downsampler
`timescale 1ns / 1ps

module area_average_downsampler_tb;

  localparam longint unsigned UNIT_POS     = 64'd1 << aad_pkg::FRAC_BITS;
  localparam longint unsigned HALF_UNIT    = 64'd1 << (aad_pkg::FRAC_BITS - 1);
  localparam longint unsigned ACC_LIMIT    = (64'd1 << aad_pkg::ACC_W) - 1;
  localparam longint unsigned AVG_LIMIT    = (64'd1 << aad_pkg::SAMPLE_BITS) - 1;
  localparam int              DRAIN_CYCLES = 16;
  localparam int              RANDOM_ITEMS = 1200;
  localparam int              LONG_COLUMN  = 360;

  typedef struct packed {
    logic [15:0] average;
    logic [11:0] index;
    logic        last;
  } bin_result_t;

  typedef enum logic [2:0] {
    ROW_ITEM, ROW_SRC_LEN, ROW_DST_LEN, ROW_BIN_W, ROW_WSCALE
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [28:0] value;
    logic        column_end;
    logic        typed;
    logic [15:0] average;
    logic [11:0] index;
    logic        last;
  } plan_row_t;

  localparam plan_row_t DIRECTED [52] = '{
    '{ROW_ITEM,    29'h0FFFF,     1'b0, 1'b1, 16'hFFFF, 12'd0, 1'b1},
    '{ROW_ITEM,    29'h00000,     1'b1, 1'b1, 16'h0000, 12'd0, 1'b1},
    // zero registers fall back to their minimum
    '{ROW_SRC_LEN, 29'd0,         1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_DST_LEN, 29'd0,         1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_BIN_W,   29'd0,         1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_WSCALE,  29'd65536,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h01234,     1'b0, 1'b1, 16'h1234, 12'd0, 1'b1},
    // largest weight saturates the average
    '{ROW_WSCALE,  29'd131071,    1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0FFFF,     1'b0, 1'b1, 16'hFFFF, 12'd0, 1'b1},
    // dest clamped to source, early column end
    '{ROW_SRC_LEN, 29'd5,         1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_DST_LEN, 29'h1FFF,      1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_BIN_W,   29'd65536,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_WSCALE,  29'd65536,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h00100,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h00200,     1'b1, 1'b0, 16'h0,    12'd0, 1'b0},
    // straddling samples, three to two
    '{ROW_SRC_LEN, 29'd3,         1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_DST_LEN, 29'd2,         1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_BIN_W,   29'd98304,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_WSCALE,  29'd43691,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h01000,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h02000,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h03000,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    // tiny head fraction dropped
    '{ROW_SRC_LEN, 29'd4,         1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_DST_LEN, 29'd2,         1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_BIN_W,   29'd131122,    1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_WSCALE,  29'd32768,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0A000,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0B000,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0C000,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0D000,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    // bins exhausted before the column ends
    '{ROW_SRC_LEN, 29'd5,         1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_DST_LEN, 29'd2,         1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_BIN_W,   29'd65536,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_WSCALE,  29'd65536,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h00011,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h00022,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h00033,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h00044,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h00055,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    // accumulator saturation in one wide bin
    '{ROW_SRC_LEN, 29'd20,        1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_DST_LEN, 29'd1,         1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_BIN_W,   29'h1FFFFFFF,  1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_WSCALE,  29'd131071,    1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0FFFF,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0FFFF,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0FFFF,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0FFFF,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0FFFF,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0FFFF,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0FFFF,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0FFFF,     1'b0, 1'b0, 16'h0,    12'd0, 1'b0},
    '{ROW_ITEM,    29'h0FFFF,     1'b1, 1'b1, 16'hFFFF, 12'd0, 1'b1}
  };

  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       in_valid      = 1'b0;
  logic                       in_ready;
  logic [15:0]                in_sample     = '0;
  logic                       in_column_end = 1'b0;
  logic                       out_valid;
  logic                       out_ready     = 1'b0;
  logic [15:0]                out_average;
  logic [11:0]                out_index;
  logic                       out_last;
  logic                       cfg_we        = 1'b0;
  logic [aad_pkg::CIDX_W-1:0] cfg_index     = '0;
  logic [aad_pkg::CFG_W-1:0]  cfg_wdata     = '0;

  area_average_downsampler dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .in_column_end (in_column_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_average   (out_average),
    .out_index     (out_index),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #1 clk = ~clk;

  // predictor copy of registers and column state
  logic [aad_pkg::LEN_W-1:0] src_len_reg  = 13'd1;
  logic [aad_pkg::LEN_W-1:0] dst_len_reg  = 13'd1;
  logic [aad_pkg::BW_W-1:0]  bin_w_reg    = 29'd65536;
  logic [aad_pkg::WS_W-1:0]  wscale_reg   = 17'd65536;
  longint unsigned           col_pos      = 0;
  longint unsigned           bin_end_pos  = UNIT_POS;
  longint unsigned           bin_count    = 0;
  longint unsigned           acc          = 0;

  bin_result_t      pending_bins [$];
  bin_result_t      bin_want;
  int               mismatch_count = 0;
  int               send_idle_pct  = 12;
  int               recv_idle_pct  = 81;
  int               random_items   = 0;

  function automatic longint unsigned eff_src_len();
    longint unsigned v;
    v = src_len_reg;
    if (v == 0) v = 1;
    if (v > aad_pkg::MAX_LENGTH) v = aad_pkg::MAX_LENGTH;
    return v;
  endfunction

  function automatic longint unsigned eff_dst_len();
    longint unsigned v;
    v = dst_len_reg;
    if (v == 0) v = 1;
    if (v > eff_src_len()) v = eff_src_len();
    return v;
  endfunction

  function automatic longint unsigned eff_bin_w();
    return (bin_w_reg < UNIT_POS) ? UNIT_POS : longint'(bin_w_reg);
  endfunction

  function automatic void restart_column();
    col_pos     = 0;
    bin_end_pos = eff_bin_w();
    bin_count   = 0;
    acc         = 0;
  endfunction

  function automatic void add_part(input longint unsigned frac, input longint unsigned value);
    longint unsigned w;
    if (frac * 1000 <= UNIT_POS) return;
    w = (frac * wscale_reg + HALF_UNIT) >> aad_pkg::FRAC_BITS;
    acc = acc + w * value;
    if (acc > ACC_LIMIT) acc = ACC_LIMIT;
  endfunction

  function automatic logic [15:0] bin_average();
    longint unsigned a;
    a = (acc + 64'd32768) >> 16;
    return (a > AVG_LIMIT) ? 16'(AVG_LIMIT) : a[15:0];
  endfunction

  function automatic bit average_sample(input logic [15:0] smp, input logic ce,
                                        output bin_result_t res);
    longint unsigned value, dst, start, stop, tail;
    bit end_col, got;
    value   = smp;
    dst     = eff_dst_len();
    start   = col_pos << aad_pkg::FRAC_BITS;
    stop    = start + UNIT_POS;
    end_col = ce || (col_pos + 1 >= eff_src_len());
    got     = 1'b0;
    res     = '0;
    if (bin_count < dst) begin
      if (stop < bin_end_pos) begin
        add_part(UNIT_POS, value);
      end else begin
        add_part(bin_end_pos - start, value);
        res.average = bin_average();
        res.index   = bin_count[11:0];
        res.last    = (bin_count + 1 == dst) || end_col;
        got         = 1'b1;
        acc         = 0;
        bin_count++;
        tail        = stop - bin_end_pos;
        bin_end_pos = bin_end_pos + eff_bin_w();
        if (bin_count < dst) add_part(tail, value);
      end
    end
    if (end_col) begin
      if (!got && bin_count < dst) begin
        res.average = bin_average();
        res.index   = bin_count[11:0];
        res.last    = 1'b1;
        got         = 1'b1;
      end
      restart_column();
    end else begin
      col_pos++;
    end
    return got;
  endfunction

  task automatic write_reg(input logic [aad_pkg::CIDX_W-1:0] ridx,
                           input logic [aad_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= ridx;
    cfg_wdata <= data;
    @(posedge clk);
    case (ridx)
      aad_pkg::REG_SRC_LEN: src_len_reg = data[aad_pkg::LEN_W-1:0];
      aad_pkg::REG_DST_LEN: dst_len_reg = data[aad_pkg::LEN_W-1:0];
      aad_pkg::REG_BIN_W:   bin_w_reg   = data[aad_pkg::BW_W-1:0];
      aad_pkg::REG_WSCALE:  wscale_reg  = data[aad_pkg::WS_W-1:0];
      default: ;
    endcase
    restart_column();
    @(negedge clk);
  endtask

  task automatic send_item(input logic [15:0] smp, input logic ce, input bit typed,
                           input bin_result_t typed_res);
    bin_result_t res;
    bit got;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= smp;
    in_column_end <= ce;
    do @(posedge clk); while (!in_ready);
    got = average_sample(smp, ce, res);
    if (typed) pending_bins.push_back(typed_res);
    else if (got) pending_bins.push_back(res);
    @(negedge clk);
  endtask

  // wait until every expected transaction is out and the pipeline is quiet
  task automatic settle();
    in_valid <= 1'b0;
    cfg_we   <= 1'b0;
    @(negedge clk);
    while (pending_bins.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected transaction average=%h index=%0d last=%b",
                 $time, out_average, out_index, out_last);
        mismatch_count++;
      end else begin
        bin_want = pending_bins.pop_front();
        if (out_average !== bin_want.average) begin
          $display("%0t: average expected %h actual %h", $time, bin_want.average, out_average);
          mismatch_count++;
        end
        if (out_index !== bin_want.index) begin
          $display("%0t: index expected %0d actual %0d", $time, bin_want.index, out_index);
          mismatch_count++;
        end
        if (out_last !== bin_want.last) begin
          $display("%0t: last expected %b actual %b", $time, bin_want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("area_average_downsampler_tb: errors");
    $finish;
  end

  initial begin
    plan_row_t                  row;
    logic [aad_pkg::CIDX_W-1:0] ridx;
    longint unsigned            src, dst, bw, ws, len, stop_at;
    int unsigned                cols, pick;
    logic                       ce;
    bit                         broken;

    restart_column();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.kind == ROW_ITEM) begin
        send_item(row.value[15:0], row.column_end, row.typed,
                  bin_result_t'{row.average, row.index, row.last});
      end else begin
        if (i > 0 && DIRECTED[i-1].kind == ROW_ITEM) settle();
        case (row.kind)
          ROW_SRC_LEN: ridx = aad_pkg::REG_SRC_LEN;
          ROW_DST_LEN: ridx = aad_pkg::REG_DST_LEN;
          ROW_BIN_W:   ridx = aad_pkg::REG_BIN_W;
          default:     ridx = aad_pkg::REG_WSCALE;
        endcase
        write_reg(ridx, row.value);
      end
    end

    while (random_items < RANDOM_ITEMS) begin
      settle();
      pick = $urandom_range(9);
      if (pick <= 6) begin
        src = $urandom_range(1, 48);
        dst = $urandom_range(1, src);
        bw  = (src << aad_pkg::FRAC_BITS) / dst + $urandom_range(0, 3);
        ws  = (dst << aad_pkg::FRAC_BITS) / src;
      end else if (pick == 7) begin
        src = $urandom & 32'h1FFF;
        dst = $urandom & 32'h1FFF;
        bw  = $urandom & 32'h1FFFFFFF;
        ws  = $urandom & 32'h1FFFF;
      end else if (pick == 8) begin
        src = $urandom_range(0, 48);
        dst = $urandom_range(0, 60);
        bw  = $urandom_range(0, 4 << aad_pkg::FRAC_BITS);
        ws  = $urandom_range(0, 131071);
      end else begin
        case ($urandom_range(3))
          0: src = 1;
          1: src = 4096;
          2: src = 0;
          default: src = 13'h1FFF;
        endcase
        case ($urandom_range(3))
          0: dst = 1;
          1: dst = 4096;
          2: dst = 0;
          default: dst = 13'h1FFF;
        endcase
        case ($urandom_range(3))
          0: bw = 65536;
          1: bw = 29'h1FFFFFFF;
          2: bw = 0;
          default: bw = 65535;
        endcase
        case ($urandom_range(3))
          0: ws = 1;
          1: ws = 65536;
          2: ws = 131071;
          default: ws = 0;
        endcase
      end
      write_reg(aad_pkg::REG_SRC_LEN, aad_pkg::CFG_W'(src));
      write_reg(aad_pkg::REG_DST_LEN, aad_pkg::CFG_W'(dst));
      write_reg(aad_pkg::REG_BIN_W, aad_pkg::CFG_W'(bw));
      write_reg(aad_pkg::REG_WSCALE, aad_pkg::CFG_W'(ws));

      cols = $urandom_range(1, 3);
      for (int c = 0; c < cols; c++) begin
        len     = (eff_src_len() <= 48) ? eff_src_len() : $urandom_range(1, 48);
        broken  = ($urandom_range(9) == 0);
        stop_at = broken ? $urandom_range(0, len - 1) : len - 1;
        for (longint unsigned k = 0; k < len; k++) begin
          if (random_items < RANDOM_ITEMS / 3) begin
            send_idle_pct = 12;
            recv_idle_pct = 81;
          end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 81;
            recv_idle_pct = 12;
          end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
          if (random_items == RANDOM_ITEMS / 2) settle();
          ce = 1'b0;
          if (k == stop_at) ce = broken || (len < eff_src_len()) || $urandom_range(1);
          if ($urandom_range(31) == 0) ce = 1'b1;
          send_item(16'($urandom), ce, 1'b0, '0);
          random_items++;
        end
      end
    end

    // one long full column
    settle();
    write_reg(aad_pkg::REG_SRC_LEN, aad_pkg::CFG_W'(LONG_COLUMN));
    write_reg(aad_pkg::REG_DST_LEN, aad_pkg::CFG_W'(1));
    write_reg(aad_pkg::REG_BIN_W, aad_pkg::CFG_W'(LONG_COLUMN << aad_pkg::FRAC_BITS));
    write_reg(aad_pkg::REG_WSCALE, aad_pkg::CFG_W'(16));
    for (int k = 0; k < LONG_COLUMN; k++) send_item(16'($urandom), 1'b0, 1'b0, '0);

    settle();
    if (mismatch_count == 0) begin
      $display("area_average_downsampler_tb: clean");
    end else begin
      $display("area_average_downsampler_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/aad_pkg.sv
rtl/core/aad_mac.sv
rtl/core/aad_seq.sv
rtl/core/area_average_downsampler.sv
test/area_average_downsampler_tb.sv
